// ----- rtl/mcst_pkg.sv -----
package mcst_pkg;

    // Field widths of one input word and one result word
    localparam int FUNC_W   = 3;
    localparam int IDX_W    = 8;
    localparam int PERIOD_W = 16;
    localparam int TICK_W   = 32;
    localparam int MASK_W   = 8;

    // Default channel count
    localparam int NUM_TIMERS_DEF = 8;

    // Command codes carried in func
    typedef enum logic [FUNC_W-1:0] {
        FUNC_TICK   = 3'd0,
        FUNC_SINGLE = 3'd1,
        FUNC_LOOP   = 3'd2,
        FUNC_STOP   = 3'd3,
        FUNC_DELAY  = 3'd4
    } func_t;

    // Per-channel command strobes, already qualified by the pipeline advance
    typedef struct packed {
        logic tick;
        logic single;
        logic loop;
        logic stop;
    } chan_cmd_t;

endpackage

// ----- rtl/mcst_chan.sv -----
module mcst_chan
    import mcst_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  chan_cmd_t           cmd,
    input  logic [PERIOD_W-1:0] period,
    output logic                fire
);

    logic                enabled_reg;
    logic                enabled_next;
    logic                periodic_reg;
    logic                periodic_next;
    logic [PERIOD_W-1:0] count_reg;
    logic [PERIOD_W-1:0] count_next;
    logic [PERIOD_W-1:0] reload_reg;
    logic [PERIOD_W-1:0] reload_next;
    logic [PERIOD_W-1:0] count_dec;

    assign count_dec = count_reg - PERIOD_W'(1);

    // Decrement on tick, reload or disable on expiry, load on arm, drop on stop
    always_comb
    begin
        enabled_next  = enabled_reg;
        periodic_next = periodic_reg;
        count_next    = count_reg;
        reload_next   = reload_reg;
        fire          = 1'b0;
        if (cmd.tick && enabled_reg)
        begin
            if (count_dec == '0)
            begin
                fire = 1'b1;
                if (periodic_reg)
                begin
                    count_next = reload_reg;
                end
                else
                begin
                    count_next   = count_dec;
                    enabled_next = 1'b0;
                end
            end
            else
            begin
                count_next = count_dec;
            end
        end
        if (cmd.single)
        begin
            count_next    = period;
            periodic_next = 1'b0;
            enabled_next  = 1'b1;
        end
        if (cmd.loop)
        begin
            count_next    = period;
            reload_next   = period;
            periodic_next = 1'b1;
            enabled_next  = 1'b1;
        end
        if (cmd.stop)
        begin
            enabled_next = 1'b0;
        end
    end

    // Hold channel state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enabled_reg  <= 1'b0;
            periodic_reg <= 1'b0;
            count_reg    <= '0;
            reload_reg   <= '0;
        end
        else
        begin
            enabled_reg  <= enabled_next;
            periodic_reg <= periodic_next;
            count_reg    <= count_next;
            reload_reg   <= reload_next;
        end
    end

endmodule

// ----- rtl/multi_channel_soft_timer.sv -----
// Bank of NUM_TIMERS one-shot / periodic timer channels with a free-running
// 32-bit tick counter and one delay watch. Each input word carries a command
// (tick, single run, loop run, stop, set delay) and produces exactly one result
// word: the mask of channels that expired on this tick (channels 0..7 only),
// whether the tick counter has passed the delay deadline, and the tick counter
// after the command. Arm commands with an out-of-range index or a zero period,
// and stop with an out-of-range index, are ignored. One word is taken every
// cycle while the result side does not stall; a result is presented once its
// word has passed the input register and then the result register, and all
// channels update in parallel in the stage between them.
module multi_channel_soft_timer
    import mcst_pkg::*;
#(
    parameter int NUM_TIMERS = NUM_TIMERS_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [FUNC_W-1:0]   func,
    input  logic [IDX_W-1:0]    timer_index,
    input  logic [PERIOD_W-1:0] period,
    input  logic [TICK_W-1:0]   delay_length,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [MASK_W-1:0]   fire_mask,
    output logic                delay_elapsed,
    output logic [TICK_W-1:0]   ms_ticks
);

    logic                  s1_valid_reg;
    func_t                 s1_func_reg;
    logic [IDX_W-1:0]      s1_idx_reg;
    logic [PERIOD_W-1:0]   s1_period_reg;
    logic [TICK_W-1:0]     s1_dlen_reg;

    logic                  out_valid_reg;
    logic [MASK_W-1:0]     fire_mask_reg;
    logic                  elapsed_reg;

    logic [TICK_W-1:0]     tick_count_reg;
    logic [TICK_W-1:0]     tick_count_next;
    logic [TICK_W-1:0]     deadline_reg;
    logic [TICK_W-1:0]     deadline_next;

    logic                  can_out;
    logic                  advance;
    logic                  take;
    logic                  is_tick;
    logic                  is_single;
    logic                  is_loop;
    logic                  is_stop;
    logic                  is_delay;
    logic                  idx_ok;
    logic                  arm_ok;
    logic [NUM_TIMERS-1:0] fire;
    logic [MASK_W-1:0]     mask_next;

    // Handshake: result register frees up when empty or taken
    assign can_out  = !out_valid_reg || !out_stall;
    assign advance  = s1_valid_reg && can_out;
    assign in_stall = s1_valid_reg && !can_out;
    assign take     = in_valid && !in_stall;

    // Capture the input word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (take)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            s1_func_reg   <= func_t'(func);
            s1_idx_reg    <= timer_index;
            s1_period_reg <= period;
            s1_dlen_reg   <= delay_length;
        end
    end

    // Decode the command; unused codes change nothing
    always_comb
    begin
        is_tick   = 1'b0;
        is_single = 1'b0;
        is_loop   = 1'b0;
        is_stop   = 1'b0;
        is_delay  = 1'b0;
        unique case (s1_func_reg)
            FUNC_TICK:   is_tick   = 1'b1;
            FUNC_SINGLE: is_single = 1'b1;
            FUNC_LOOP:   is_loop   = 1'b1;
            FUNC_STOP:   is_stop   = 1'b1;
            FUNC_DELAY:  is_delay  = 1'b1;
            default:     ;
        endcase
    end

    assign idx_ok = s1_idx_reg < IDX_W'(NUM_TIMERS);
    assign arm_ok = idx_ok && (s1_period_reg != '0);

    // Channel bank
    for (genvar g = 0; g < NUM_TIMERS; g++)
    begin : g_chan
        logic      sel;
        chan_cmd_t cmd;

        assign sel        = (s1_idx_reg == IDX_W'(g));
        assign cmd.tick   = advance && is_tick;
        assign cmd.single = advance && is_single && arm_ok && sel;
        assign cmd.loop   = advance && is_loop && arm_ok && sel;
        assign cmd.stop   = advance && is_stop && idx_ok && sel;

        mcst_chan u_chan
        (
            .clk    (clk),
            .rst_n  (rst_n),
            .cmd    (cmd),
            .period (s1_period_reg),
            .fire   (fire[g])
        );
    end

    // Drop fire bits of channels beyond the mask width
    for (genvar b = 0; b < MASK_W; b++)
    begin : g_mask
        if (b < NUM_TIMERS)
        begin : g_live
            assign mask_next[b] = fire[b];
        end
        else
        begin : g_none
            assign mask_next[b] = 1'b0;
        end
    end

    // Advance the tick counter and snapshot the delay deadline
    assign tick_count_next = tick_count_reg + TICK_W'(advance && is_tick);
    assign deadline_next   = (advance && is_delay) ? tick_count_reg + s1_dlen_reg
                                                   : deadline_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_count_reg <= '0;
            deadline_reg   <= '0;
        end
        else
        begin
            tick_count_reg <= tick_count_next;
            deadline_reg   <= deadline_next;
        end
    end

    // Hold the result word until taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            fire_mask_reg <= mask_next;
            elapsed_reg   <= tick_count_next > deadline_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign fire_mask     = fire_mask_reg;
    assign delay_elapsed = elapsed_reg;
    assign ms_ticks      = tick_count_reg;

endmodule

// ----- tb/multi_channel_soft_timer_tb.sv -----
`timescale 1ns / 1ps

module multi_channel_soft_timer_tb;
    import mcst_pkg::*;

    // Codes outside the command set, accepted and ignored by the block
    localparam logic [FUNC_W-1:0] FUNC_UNUSED_LO = 3'd5;
    localparam logic [FUNC_W-1:0] FUNC_UNUSED_HI = 3'd7;

    localparam int NUM_RANDOM_WORDS = 1300;
    localparam int CYCLE_LIMIT      = 200000;
    localparam int DRAIN_CYCLES     = 8;
    localparam int NUM_DIRECTED     = 26;

    typedef struct packed {
        logic [MASK_W-1:0] mask;
        logic              elapsed;
        logic [TICK_W-1:0] ticks;
    } timer_result_t;

    typedef struct packed {
        logic [FUNC_W-1:0]   f;
        logic [IDX_W-1:0]    idx;
        logic [PERIOD_W-1:0] per;
        logic [TICK_W-1:0]   dlen;
        logic                fixed;
        timer_result_t       res;
    } stim_row_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                in_valid = 1'b0;
    logic                in_stall;
    logic [FUNC_W-1:0]   func = FUNC_TICK;
    logic [IDX_W-1:0]    timer_index = '0;
    logic [PERIOD_W-1:0] period = '0;
    logic [TICK_W-1:0]   delay_length = '0;
    logic                out_valid;
    logic                out_stall = 1'b0;
    logic [MASK_W-1:0]   fire_mask;
    logic                delay_elapsed;
    logic [TICK_W-1:0]   ms_ticks;

    // Expectation typed into the directed table, travels with the word
    logic                fixed_en = 1'b0;
    timer_result_t       fixed_res = '0;

    // Shadow copy of the timer bank
    logic                chan_on  [NUM_TIMERS_DEF];
    logic [PERIOD_W-1:0] chan_cnt [NUM_TIMERS_DEF];
    logic [PERIOD_W-1:0] chan_rel [NUM_TIMERS_DEF];
    logic                chan_per [NUM_TIMERS_DEF];
    logic [TICK_W-1:0]   tick_cnt = '0;
    logic [TICK_W-1:0]   dly_start = '0;
    logic [TICK_W-1:0]   dly_amount = '0;

    timer_result_t       due_results [$];
    stim_row_t           dir_rows [NUM_DIRECTED];

    int                  send_idle_pct = 0;
    int                  recv_stall_pct = 0;
    int                  mismatches = 0;
    int                  words_taken = 0;
    int                  results_seen = 0;
    int                  ticks_taken = 0;
    int                  fire_events = 0;
    int                  elapsed_seen = 0;
    int                  cycle_count = 0;

    multi_channel_soft_timer uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .func          (func),
        .timer_index   (timer_index),
        .period        (period),
        .delay_length  (delay_length),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .fire_mask     (fire_mask),
        .delay_elapsed (delay_elapsed),
        .ms_ticks      (ms_ticks)
    );

    always #1 clk = ~clk;

    // Print one mismatch line and count it
    task automatic report_mismatch(input string what, input logic [TICK_W-1:0] got,
                                   input logic [TICK_W-1:0] want);
        $display("MISMATCH at %0t: %s got 0x%0h expected 0x%0h", $realtime, what, got, want);
        mismatches++;
    endtask

    // Apply one word to the shadow bank and return the result it yields
    task automatic advance_timers(input logic [FUNC_W-1:0] f, input logic [IDX_W-1:0] idx,
                                  input logic [PERIOD_W-1:0] per,
                                  input logic [TICK_W-1:0] dlen, output timer_result_t r);
        logic idx_ok;
        idx_ok = idx < IDX_W'(NUM_TIMERS_DEF);
        r = '0;
        case (f)
            FUNC_TICK:
            begin
                for (int i = 0; i < NUM_TIMERS_DEF; i++)
                begin
                    if (chan_on[i])
                    begin
                        chan_cnt[i] = chan_cnt[i] - PERIOD_W'(1);
                        if (chan_cnt[i] == '0)
                        begin
                            if (i < MASK_W)
                                r.mask[i] = 1'b1;
                            if (chan_per[i])
                                chan_cnt[i] = chan_rel[i];
                            else
                                chan_on[i] = 1'b0;
                        end
                    end
                end
                tick_cnt = tick_cnt + TICK_W'(1);
            end
            FUNC_SINGLE:
            begin
                if (idx_ok && per != '0)
                begin
                    chan_cnt[idx] = per;
                    chan_per[idx] = 1'b0;
                    chan_on[idx]  = 1'b1;
                end
            end
            FUNC_LOOP:
            begin
                if (idx_ok && per != '0)
                begin
                    chan_cnt[idx] = per;
                    chan_rel[idx] = per;
                    chan_per[idx] = 1'b1;
                    chan_on[idx]  = 1'b1;
                end
            end
            FUNC_STOP:
            begin
                if (idx_ok)
                    chan_on[idx] = 1'b0;
            end
            FUNC_DELAY:
            begin
                dly_amount = dlen;
                dly_start  = tick_cnt;
            end
            default:
            begin
            end
        endcase
        r.elapsed = tick_cnt > (dly_start + dly_amount);
        r.ticks   = tick_cnt;
    endtask

    // Check taken results against the oldest expectation, then queue new ones
    always @(posedge clk)
    begin : word_monitor
        timer_result_t got;
        timer_result_t want;
        timer_result_t calc;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                got = '{fire_mask, delay_elapsed, ms_ticks};
                results_seen++;
                if (due_results.size() == 0)
                begin
                    report_mismatch("result with nothing pending", got.ticks, '0);
                end
                else
                begin
                    want = due_results.pop_front();
                    if (got.mask !== want.mask)
                        report_mismatch("fire_mask", TICK_W'(got.mask), TICK_W'(want.mask));
                    if (got.elapsed !== want.elapsed)
                        report_mismatch("delay_elapsed", TICK_W'(got.elapsed),
                                        TICK_W'(want.elapsed));
                    if (got.ticks !== want.ticks)
                        report_mismatch("ms_ticks", got.ticks, want.ticks);
                end
            end
            if (in_valid && !in_stall)
            begin
                advance_timers(func, timer_index, period, delay_length, calc);
                words_taken++;
                if (func == FUNC_TICK)
                    ticks_taken++;
                fire_events  += $countones(calc.mask);
                elapsed_seen += int'(calc.elapsed);
                due_results.push_back(fixed_en ? fixed_res : calc);
            end
        end
    end

    // Stall the result side at random
    always @(negedge clk)
        out_stall <= ($urandom_range(99) < recv_stall_pct);

    // Give up on a hung run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("Some tests failed");
            $finish;
        end
    end

    // Drive one word from a falling edge, hold it until taken
    task automatic send_word(input logic [FUNC_W-1:0] f, input logic [IDX_W-1:0] idx,
                             input logic [PERIOD_W-1:0] per, input logic [TICK_W-1:0] dlen,
                             input logic fix, input timer_result_t fix_res);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid     <= 1'b1;
        func         <= f;
        timer_index  <= idx;
        period       <= per;
        delay_length <= dlen;
        fixed_en     <= fix;
        fixed_res    <= fix_res;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Pick a mostly well-formed command; report whether the block acts on it
    task automatic pick_word(output logic [FUNC_W-1:0] f, output logic [IDX_W-1:0] idx,
                             output logic [PERIOD_W-1:0] per, output logic [TICK_W-1:0] dlen,
                             output bit counts);
        int sel;
        sel = $urandom_range(99);
        if (sel < 40)
            f = FUNC_TICK;
        else if (sel < 62)
            f = FUNC_SINGLE;
        else if (sel < 80)
            f = FUNC_LOOP;
        else if (sel < 88)
            f = FUNC_STOP;
        else if (sel < 96)
            f = FUNC_DELAY;
        else
            f = FUNC_W'($urandom_range(FUNC_UNUSED_HI, FUNC_UNUSED_LO));

        idx = ($urandom_range(9) == 0) ? IDX_W'($urandom_range(255))
                                       : IDX_W'($urandom_range(NUM_TIMERS_DEF - 1));

        sel = $urandom_range(19);
        if (sel == 0)
            per = '0;
        else if (sel == 1)
            per = PERIOD_W'($urandom_range(16'hFFFF));
        else
            per = PERIOD_W'($urandom_range(12, 1));

        dlen = ($urandom_range(7) == 0) ? $urandom() : $urandom_range(30);

        case (f)
            FUNC_TICK, FUNC_DELAY: counts = 1'b1;
            FUNC_SINGLE, FUNC_LOOP: counts = (idx < IDX_W'(NUM_TIMERS_DEF)) && (per != '0);
            FUNC_STOP: counts = idx < IDX_W'(NUM_TIMERS_DEF);
            default: counts = 1'b0;
        endcase
    endtask

    initial
    begin : stimulus
        logic [FUNC_W-1:0]   f;
        logic [IDX_W-1:0]    idx;
        logic [PERIOD_W-1:0] per;
        logic [TICK_W-1:0]   dlen;
        bit                  counts;
        int                  done;
        int                  phase_len;

        for (int i = 0; i < NUM_DIRECTED; i++)
        begin
            chan_on[i % NUM_TIMERS_DEF]  = 1'b0;
            chan_cnt[i % NUM_TIMERS_DEF] = '0;
            chan_rel[i % NUM_TIMERS_DEF] = '0;
            chan_per[i % NUM_TIMERS_DEF] = 1'b0;
        end

        // Directed words; fixed rows carry their own expected result
        dir_rows = '{
            '{FUNC_TICK,      8'd0,   16'd0,     32'd0,          1'b1, '{8'h00, 1'b1, 32'd1}},
            '{FUNC_SINGLE,    8'd0,   16'd1,     32'd0,          1'b1, '{8'h00, 1'b1, 32'd1}},
            '{FUNC_TICK,      8'd0,   16'd0,     32'd0,          1'b1, '{8'h01, 1'b1, 32'd2}},
            '{FUNC_LOOP,      8'd7,   16'd2,     32'd0,          1'b0, '0},
            '{FUNC_LOOP,      8'd8,   16'd5,     32'd0,          1'b1, '{8'h00, 1'b1, 32'd2}},
            '{FUNC_SINGLE,    8'd255, 16'hFFFF,  32'd0,          1'b1, '{8'h00, 1'b1, 32'd2}},
            '{FUNC_SINGLE,    8'd3,   16'd0,     32'd0,          1'b1, '{8'h00, 1'b1, 32'd2}},
            '{FUNC_LOOP,      8'd1,   16'd0,     32'd0,          1'b1, '{8'h00, 1'b1, 32'd2}},
            '{FUNC_TICK,      8'd0,   16'd0,     32'd0,          1'b0, '0},
            '{FUNC_TICK,      8'd0,   16'd0,     32'd0,          1'b0, '0},
            '{FUNC_DELAY,     8'd0,   16'd0,     32'hFFFF_FFFF,  1'b1, '{8'h00, 1'b1, 32'd4}},
            '{FUNC_DELAY,     8'd0,   16'd0,     32'd0,          1'b1, '{8'h00, 1'b0, 32'd4}},
            '{FUNC_TICK,      8'd0,   16'd0,     32'd0,          1'b0, '0},
            '{FUNC_DELAY,     8'd0,   16'd0,     32'd3,          1'b0, '0},
            '{FUNC_LOOP,      8'd2,   16'hFFFF,  32'd0,          1'b0, '0},
            '{FUNC_STOP,      8'd7,   16'd0,     32'd0,          1'b0, '0},
            '{FUNC_STOP,      8'd200, 16'd0,     32'd0,          1'b1, '{8'h00, 1'b0, 32'd5}},
            '{FUNC_TICK,      8'd0,   16'd0,     32'd0,          1'b0, '0},
            '{FUNC_UNUSED_LO, 8'd255, 16'hFFFF,  32'hFFFF_FFFF,  1'b1, '{8'h00, 1'b0, 32'd6}},
            '{FUNC_UNUSED_HI, 8'd0,   16'd1,     32'd0,          1'b1, '{8'h00, 1'b0, 32'd6}},
            '{FUNC_SINGLE,    8'd7,   16'd1,     32'd0,          1'b0, '0},
            '{FUNC_SINGLE,    8'd4,   16'd1,     32'd0,          1'b0, '0},
            '{FUNC_TICK,      8'd0,   16'd0,     32'd0,          1'b0, '0},
            '{FUNC_LOOP,      8'd5,   16'd1,     32'd0,          1'b0, '0},
            '{FUNC_TICK,      8'd0,   16'd0,     32'd0,          1'b0, '0},
            '{FUNC_TICK,      8'd0,   16'd0,     32'd0,          1'b0, '0}
        };

        // Hold reset, release on a falling edge
        repeat (4) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        for (int i = 0; i < NUM_DIRECTED; i++)
            send_word(dir_rows[i].f, dir_rows[i].idx, dir_rows[i].per, dir_rows[i].dlen,
                      dir_rows[i].fixed, dir_rows[i].res);

        // Random words across the idling phases
        phase_len = NUM_RANDOM_WORDS / 4;
        for (int ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 49; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 49; end
                default: begin send_idle_pct = 25; recv_stall_pct = 25; end
            endcase
            done = 0;
            while (done < phase_len)
            begin
                pick_word(f, idx, per, dlen, counts);
                send_word(f, idx, per, dlen, 1'b0, '0);
                if (counts)
                    done++;
            end
        end
        in_valid <= 1'b0;

        // Drain outstanding results, then watch for strays
        while (due_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Ran %0d words (%0d ticks) through directed and random phases with idling",
                 words_taken, ticks_taken);
        $display("Checked %0d results: %0d channel firings, %0d with delay elapsed",
                 results_seen, fire_events, elapsed_seen);
        if (mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

// ----- multi_channel_soft_timer.f -----
rtl/mcst_pkg.sv
rtl/mcst_chan.sv
rtl/multi_channel_soft_timer.sv
tb/multi_channel_soft_timer_tb.sv
